/* design/sobel_gradient_magnitude_defines.svh */
// Assertion macros for the gradient block
`ifndef SOBEL_GRADIENT_MAGNITUDE_DEFINES_SVH
`define SOBEL_GRADIENT_MAGNITUDE_DEFINES_SVH
`ifndef SYNTH
`define SGM_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define SGM_ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define SGM_ASSERT_IMP(label, clk, rst_n, a, c)
`define SGM_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

/* design/sgm_pkg.sv */
`timescale 1ns / 1ps
package sgm_pkg;
    localparam int MaxWidth = 2048;
    localparam int AddrW = $clog2(MaxWidth);
    localparam logic [1:0] CfgWidth = 2'd0;
    localparam logic [1:0] CfgHeight = 2'd1;
    localparam logic [1:0] CfgEdge = 2'd2;

    // one gradient job: three columns left/center/right, rows top/mid/bottom
    typedef struct packed {
        logic [15:0] t0, t1, t2, m0, m1, m2, b0, b1, b2;
        logic [15:0] row;
        logic [10:0] col;
        logic        last;
        logic        eof;
    } t_job;

    typedef struct packed {
        logic [15:0] mag;
        logic [15:0] row;
        logic [10:0] col;
        logic        last;
        logic        eof;
    } t_res;
endpackage

/* design/sgm_line_ram.sv */
`timescale 1ns / 1ps
module sgm_line_ram #(
    parameter int Depth = 2048,
    parameter int Width = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

/* design/sgm_mag.sv */
`timescale 1ns / 1ps
`include "sobel_gradient_magnitude_defines.svh"
// Gradient, squares, then a 2-bit-per-cycle square root.
module sgm_mag (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  sgm_pkg::t_job i_job,
    output logic          o_valid,
    input  logic          i_take,
    output sgm_pkg::t_res o_res
);
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001, S_SQ = 4'b0010, S_ROOT = 4'b0100, S_DONE = 4'b1000
    } t_state;
    t_state r_state;
    logic signed [18:0] r_gx, r_gy;
    logic [36:0] r_v;
    logic [18:0] r_res;
    logic [4:0]  r_cnt;
    logic [15:0] r_row;
    logic [10:0] r_col;
    logic r_last, r_eof;
    logic signed [18:0] gx, gy;
    logic signed [37:0] sqx, sqy;
    logic [37:0] sq;
    logic [20:0] trial;

    always_comb begin
        gx = 19'(signed'({3'b0, i_job.t2})) + 19'(signed'({2'b0, i_job.m2, 1'b0}))
           + 19'(signed'({3'b0, i_job.b2})) - 19'(signed'({3'b0, i_job.t0}))
           - 19'(signed'({2'b0, i_job.m0, 1'b0})) - 19'(signed'({3'b0, i_job.b0}));
        gy = 19'(signed'({3'b0, i_job.t0})) + 19'(signed'({2'b0, i_job.t1, 1'b0}))
           + 19'(signed'({3'b0, i_job.t2})) - 19'(signed'({3'b0, i_job.b0}))
           - 19'(signed'({2'b0, i_job.b1, 1'b0})) - 19'(signed'({3'b0, i_job.b2}));
        sqx = r_gx * r_gx;
        sqy = r_gy * r_gy;
        sq = unsigned'(sqx) + unsigned'(sqy);
        trial = {r_res, 2'b01};
    end

    // restoring root: r_v holds the remainder shifted, r_res the partial root
    logic [37:0] cand;
    always_comb cand = 38'(trial) << (2 * r_cnt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: if (i_valid) r_state <= S_SQ;
                S_SQ:   r_state <= S_ROOT;
                S_ROOT: if (r_cnt == 5'd0) r_state <= S_DONE;
                S_DONE: if (i_take) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
        case (r_state)
            S_IDLE: if (i_valid) begin
                r_gx <= gx; r_gy <= gy;
                r_row <= i_job.row; r_col <= i_job.col;
                r_last <= i_job.last; r_eof <= i_job.eof;
            end
            S_SQ: begin
                r_v <= 37'(sq >> 5);
                r_res <= '0;
                r_cnt <= 5'd18;
            end
            S_ROOT: begin
                if ({1'b0, r_v} >= cand) begin
                    r_v <= 37'({1'b0, r_v} - cand);
                    r_res <= {r_res[17:0], 1'b1};
                end else begin
                    r_res <= {r_res[17:0], 1'b0};
                end
                if (r_cnt != 5'd0) r_cnt <= r_cnt - 5'd1;
            end
            default: ;
        endcase
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_DONE);
    assign o_res.mag = (r_res > 19'd65535) ? 16'hFFFF : r_res[15:0];
    assign o_res.row = r_row;
    assign o_res.col = r_col;
    assign o_res.last = r_last;
    assign o_res.eof = r_eof;

    `SGM_ASSERT_NXT(a_start, i_clk, i_rst_n, r_state == S_IDLE && i_valid, r_state == S_SQ)
    `SGM_ASSERT_NXT(a_hold, i_clk, i_rst_n, o_valid && !i_take, o_valid && $stable(o_res))
    `SGM_ASSERT_IMP(a_cnt, i_clk, i_rst_n, r_state == S_ROOT, r_cnt <= 5'd18)
endmodule

/* design/sobel_gradient_magnitude.sv */
`timescale 1ns / 1ps
`include "sobel_gradient_magnitude_defines.svh"
// Channel   Handshake          Payload
// pixel     i_valid/o_stall    i_pixel
// result    o_valid/i_stall    o_magnitude o_out_row o_out_col o_last_of_run o_end_of_frame
// config    i_cfg_valid/o_cfg_ready  i_cfg_index i_cfg_data
// A pixel is taken in IDLE; READ then reads both line RAMs and shifts the window.
// Each result then passes through the shared root unit (job, squares, root steps, output);
// a pixel gives at most four results, and a pixel with no result returns to IDLE after JOB.
// Reset (synchronous, active low) clears counters, window and registers to defaults.
// Line RAM contents are not cleared. A stalled result holds the whole pipe.
module sobel_gradient_magnitude (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_pixel,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_magnitude,
    output logic [15:0] o_out_row,
    output logic [10:0] o_out_col,
    output logic        o_last_of_run,
    output logic        o_end_of_frame,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    localparam int AW = sgm_pkg::AddrW;
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001, S_READ = 5'b00010, S_JOB = 5'b00100,
        S_WAIT = 5'b01000, S_OUT = 5'b10000
    } t_state;
    t_state r_state;
    logic [11:0] r_w;
    logic [15:0] r_h;
    logic r_rep;
    logic [15:0] r_row;
    logic [11:0] r_col;
    logic [15:0] r_pix;
    logic [15:0] r_win [9];
    logic [1:0] r_k, r_n;
    logic [15:0] rd_a, rd_t;
    logic [11:0] w_eff, c_eff;
    logic [15:0] h_eff;
    logic end_row, last_row;
    logic [AW-1:0] addr;
    logic mag_ready, mag_valid, job_valid;
    sgm_pkg::t_job job;
    sgm_pkg::t_res res;

    always_comb begin
        w_eff = (r_w < 12'd2) ? 12'd2 :
                (r_w > 12'(sgm_pkg::MaxWidth)) ? 12'(sgm_pkg::MaxWidth) : r_w;
        h_eff = (r_h < 16'd2) ? 16'd2 : r_h;
        c_eff = r_col;
        end_row = (c_eff >= w_eff - 12'd1);
        last_row = (r_row >= h_eff - 16'd1);
        addr = c_eff[AW-1:0];
    end

    logic we;
    logic [15:0] a_val, t_val;
    assign we = (r_state == S_READ);
    assign a_val = (r_row >= 16'd1) ? rd_a : 16'd0;
    assign t_val = (r_row >= 16'd2) ? rd_t : a_val;

    sgm_line_ram #(.Depth(sgm_pkg::MaxWidth), .Width(16)) u_above (
        .i_clk(i_clk), .i_we(we), .i_waddr(addr), .i_wdata(r_pix),
        .i_raddr(addr), .o_rdata(rd_a));
    sgm_line_ram #(.Depth(sgm_pkg::MaxWidth), .Width(16)) u_two (
        .i_clk(i_clk), .i_we(we && r_row >= 16'd1), .i_waddr(addr), .i_wdata(rd_a),
        .i_raddr(addr), .o_rdata(rd_t));

    // job k: 0 row r-1 col c-1, 1 row r col c-1, 2 row r-1 col c, 3 row r col c
    logic [1:0] kk;
    logic       right;
    logic [15:0] L [3], C [3], R [3];
    always_comb begin
        kk = r_k;
        right = kk[1];
        for (int i = 0; i < 3; i++) begin
            if (!right) begin
                C[i] = r_win[3*i+1];
                R[i] = r_win[3*i+2];
                L[i] = (r_col >= 12'd2) ? r_win[3*i] : (r_rep ? r_win[3*i+1] : 16'd0);
            end else begin
                L[i] = r_win[3*i+1];
                C[i] = r_win[3*i+2];
                R[i] = r_rep ? r_win[3*i+2] : 16'd0;
            end
        end
        if (!kk[0]) begin
            job.t0 = L[0]; job.t1 = C[0]; job.t2 = R[0];
            job.m0 = L[1]; job.m1 = C[1]; job.m2 = R[1];
            job.b0 = L[2]; job.b1 = C[2]; job.b2 = R[2];
            job.row = r_row - 16'd1;
        end else begin
            job.t0 = L[1]; job.t1 = C[1]; job.t2 = R[1];
            job.m0 = L[2]; job.m1 = C[2]; job.m2 = R[2];
            job.b0 = L[2]; job.b1 = C[2]; job.b2 = R[2];
            job.row = r_row;
        end
        job.col = right ? r_col[10:0] : 11'(r_col - 12'd1);
        job.last = (r_k == r_n);
        job.eof = (r_k == r_n) && last_row && end_row;
    end

    // next job index after r_k, skipping ones not emitted
    logic [1:0] k_first, k_next;
    logic has_first;
    always_comb begin
        has_first = (r_row >= 16'd1) && ((r_col >= 12'd1) || end_row);
        k_first = (r_col >= 12'd1) ? 2'd0 : 2'd2;
        k_next = last_row ? r_k + 2'd1 : r_k + 2'd2;
    end

    assign job_valid = (r_state == S_JOB) && has_first;

    sgm_mag u_mag (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(job_valid), .o_ready(mag_ready),
        .i_job(job), .o_valid(mag_valid), .i_take(!i_stall), .o_res(res));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_w <= 12'd1024; r_h <= 16'd1024; r_rep <= 1'b1;
            r_row <= '0; r_col <= '0;
            for (int i = 0; i < 9; i++) r_win[i] <= '0;
            r_k <= '0; r_n <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    sgm_pkg::CfgWidth:  r_w <= i_cfg_data[11:0];
                    sgm_pkg::CfgHeight: r_h <= i_cfg_data;
                    sgm_pkg::CfgEdge:   r_rep <= i_cfg_data[0];
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: if (i_valid) begin
                    r_pix <= i_pixel;
                    if (r_col >= 12'(sgm_pkg::MaxWidth)) r_col <= 12'(sgm_pkg::MaxWidth - 1);
                    r_state <= S_READ;
                end
                S_READ: r_state <= S_JOB;
                // no result: drop back to idle and advance counters
                S_JOB: r_state <= has_first ? S_WAIT : S_IDLE;
                S_WAIT: r_state <= S_OUT;
                S_OUT: begin
                    if (mag_valid && !i_stall) begin
                        if (r_k == r_n) r_state <= S_IDLE;
                        else begin
                            r_k <= k_next;
                            r_state <= S_JOB;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            // window shift and job plan at the end of READ
            if (r_state == S_READ) begin
                for (int i = 0; i < 3; i++) begin
                    r_win[3*i] <= r_win[3*i+1];
                    r_win[3*i+1] <= r_win[3*i+2];
                end
                r_win[2] <= t_val; r_win[5] <= a_val; r_win[8] <= r_pix;
            end
            if (r_state == S_READ) begin
                r_k <= k_first;
                r_n <= end_row ? (last_row ? 2'd3 : 2'd2) : (last_row ? 2'd1 : 2'd0);
            end
            if ((r_state == S_JOB && !has_first) ||
                (r_state == S_OUT && mag_valid && !i_stall && r_k == r_n)) begin
                if (end_row) begin
                    r_col <= '0;
                    r_row <= last_row ? 16'd0 : r_row + 16'd1;
                end else begin
                    r_col <= r_col + 12'd1;
                end
            end
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_valid = mag_valid && (r_state == S_OUT);
    assign o_magnitude = res.mag;
    assign o_out_row = res.row;
    assign o_out_col = res.col;
    assign o_last_of_run = res.last;
    assign o_end_of_frame = res.eof;

    `SGM_ASSERT_IMP(a_out_state, i_clk, i_rst_n, o_valid, r_state == S_OUT)
    `SGM_ASSERT_IMP(a_job_ready, i_clk, i_rst_n, r_state == S_JOB && has_first, mag_ready)
    `SGM_ASSERT_IMP(a_eof_last, i_clk, i_rst_n, o_valid && o_end_of_frame, o_last_of_run)
endmodule

/* sim/sobel_gradient_magnitude_test.sv */
`timescale 1ns / 1ps
module sobel_gradient_magnitude_test;
    localparam logic [1:0] CfgUnused = 2'd3;
    localparam int QuietLimit = 5000;
    localparam int SettleCycles = 100;

    typedef enum logic { ROW_CFG, ROW_PIX } t_row_kind;
    typedef struct {
        t_row_kind   kind;
        logic [1:0]  idx;
        logic [15:0] val;
        bit          known;
        logic [15:0] mag;
    } t_dir_row;

    logic        i_clk, i_rst_n;
    logic        i_valid, o_stall;
    logic [15:0] i_pixel;
    logic        o_valid, i_stall;
    logic [15:0] o_magnitude, o_out_row;
    logic [10:0] o_out_col;
    logic        o_last_of_run, o_end_of_frame;
    logic        i_cfg_valid, o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    sobel_gradient_magnitude DUT (.*);

    // predictor state
    logic [15:0] line_prev[sgm_pkg::MaxWidth];
    logic [15:0] line_prev2[sgm_pkg::MaxWidth];
    int unsigned win[3][3];
    int unsigned row_q, col_q;
    int unsigned width_reg, height_reg;
    bit          replicate_reg;
    sgm_pkg::t_res mag_q[$];

    int errors, pixels_sent, results_seen, cfg_writes, quiet;
    int idle_pct, stall_pct;
    logic [15:0] last_pix;
    t_dir_row    dir_q[$];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned root_floor(longint unsigned v);
        longint unsigned res, cand;
        res = 0;
        for (int b = 31; b >= 0; b--) begin
            cand = res | (64'd1 << b);
            if (cand * cand <= v) res = cand;
        end
        return int'(res);
    endfunction

    // rows: top, mid, bottom; columns: left, center, right
    function automatic logic [15:0] sobel_mag(int unsigned t[3], int unsigned m[3],
                                              int unsigned b[3]);
        longint gx, gy;
        longint unsigned s;
        int unsigned r;
        gx = (longint'(t[2]) + 2 * longint'(m[2]) + longint'(b[2]))
           - (longint'(t[0]) + 2 * longint'(m[0]) + longint'(b[0]));
        gy = (longint'(t[0]) + 2 * longint'(t[1]) + longint'(t[2]))
           - (longint'(b[0]) + 2 * longint'(b[1]) + longint'(b[2]));
        s = longint'(gx * gx) + longint'(gy * gy);
        r = root_floor(s >> 5);
        return (r > 65535) ? 16'hFFFF : r[15:0];
    endfunction

    function automatic int unsigned eff_width();
        return (width_reg < 2) ? 2 :
               (width_reg > sgm_pkg::MaxWidth) ? sgm_pkg::MaxWidth : width_reg;
    endfunction

    function automatic int unsigned eff_height();
        return (height_reg < 2) ? 2 : height_reg;
    endfunction

    function automatic int predict_pixel(logic [15:0] p);
        int unsigned w, h, r, c, above, two_above;
        int unsigned cols[3][3];
        bit end_row, last_row;
        int n;
        sgm_pkg::t_res res;
        w = eff_width();
        h = eff_height();
        r = row_q;
        c = (col_q >= sgm_pkg::MaxWidth) ? sgm_pkg::MaxWidth - 1 : col_q;
        n = 0;
        above = (r >= 1) ? line_prev[c] : 0;
        two_above = (r >= 2) ? line_prev2[c] : above;
        for (int i = 0; i < 3; i++) begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
        end
        win[0][2] = two_above;
        win[1][2] = above;
        win[2][2] = p;
        if (r >= 1) line_prev2[c] = line_prev[c];
        line_prev[c] = p;
        end_row = (c >= w - 1);
        last_row = (r >= h - 1);
        if (r >= 1) begin
            for (int k = 0; k < 2; k++) begin
                if ((k == 0 && c < 1) || (k == 1 && !end_row)) continue;
                for (int i = 0; i < 3; i++) begin
                    if (k == 0) begin
                        cols[i][1] = win[i][1];
                        cols[i][2] = win[i][2];
                        cols[i][0] = (c >= 2) ? win[i][0] : (replicate_reg ? win[i][1] : 0);
                    end else begin
                        cols[i][0] = win[i][1];
                        cols[i][1] = win[i][2];
                        cols[i][2] = replicate_reg ? win[i][2] : 0;
                    end
                end
                res = '0;
                res.col = 11'((k == 0) ? c - 1 : c);
                res.row = 16'(r - 1);
                res.mag = sobel_mag(cols[0], cols[1], cols[2]);
                mag_q.push_back(res);
                n++;
                if (last_row) begin
                    res.row = 16'(r);
                    res.mag = sobel_mag(cols[1], cols[2], cols[2]);
                    mag_q.push_back(res);
                    n++;
                end
            end
            if (n > 0) begin
                mag_q[$].last = 1'b1;
                if (last_row && end_row) mag_q[$].eof = 1'b1;
            end
        end
        if (end_row) begin
            col_q = 0;
            row_q = last_row ? 0 : r + 1;
        end else begin
            col_q = c + 1;
        end
        return n;
    endfunction

    function automatic logic [15:0] rand_pixel();
        case ($urandom_range(3))
            0: rand_pixel = 16'($urandom);
            1: rand_pixel = 16'h0000;
            2: rand_pixel = 16'hFFFF;
            default: rand_pixel = last_pix + 16'($urandom_range(255));
        endcase
        last_pix = rand_pixel;
    endfunction

    task automatic send_pixel(logic [15:0] p, bit known, logic [15:0] mag);
        int n;
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_pixel = p;
        do @(posedge i_clk); while (o_stall);
        n = predict_pixel(p);
        pixels_sent++;
        if (known)
            for (int i = 0; i < n; i++) mag_q[mag_q.size() - 1 - i].mag = mag;
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (mag_q.size() != 0) @(negedge i_clk);
        repeat (SettleCycles) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] data);
        wait_idle();
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            sgm_pkg::CfgWidth:  width_reg = data[11:0];
            sgm_pkg::CfgHeight: height_reg = data;
            sgm_pkg::CfgEdge:   replicate_reg = data[0];
            default: ;
        endcase
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // finish the current frame so that a width change never reads stale lines
    task automatic flush_frame();
        while (row_q != 0 || col_q != 0) send_pixel(rand_pixel(), 0, '0);
    endtask

    task automatic send_frames(int min_items);
        int sent;
        sent = 0;
        while (sent < min_items) begin
            for (int i = 0; i < eff_width() * eff_height(); i++)
                send_pixel(rand_pixel(), 0, '0);
            sent += eff_width() * eff_height();
        end
    endtask

    task automatic random_setup();
        flush_frame();
        write_reg(sgm_pkg::CfgWidth, 16'($urandom_range(2, 8)));
        write_reg(sgm_pkg::CfgHeight, 16'($urandom_range(2, 4)));
        write_reg(sgm_pkg::CfgEdge, 16'($urandom_range(1)));
    endtask

    always @(negedge i_clk)
        i_stall = ($urandom_range(99) < stall_pct);

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            if (mag_q.size() == 0) begin
                $error("result with nothing expected: row %0d col %0d", o_out_row, o_out_col);
                errors++;
            end else begin
                sgm_pkg::t_res e;
                e = mag_q.pop_front();
                if (o_magnitude !== e.mag) begin
                    $error("magnitude: expected %0d, got %0d", e.mag, o_magnitude);
                    errors++;
                end
                if (o_out_row !== e.row) begin
                    $error("out_row: expected %0d, got %0d", e.row, o_out_row);
                    errors++;
                end
                if (o_out_col !== e.col) begin
                    $error("out_col: expected %0d, got %0d", e.col, o_out_col);
                    errors++;
                end
                if (o_last_of_run !== e.last) begin
                    $error("last_of_run: expected %0b, got %0b", e.last, o_last_of_run);
                    errors++;
                end
                if (o_end_of_frame !== e.eof) begin
                    $error("end_of_frame: expected %0b, got %0b", e.eof, o_end_of_frame);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet <= 0;
        end else if (quiet >= QuietLimit) begin
            $display("status: fail");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    initial begin
        errors = 0; pixels_sent = 0; results_seen = 0; cfg_writes = 0; quiet = 0;
        idle_pct = 0; stall_pct = 0; last_pix = '0;
        i_rst_n = 1'b0; i_valid = 1'b0; i_pixel = '0; i_stall = 1'b0;
        i_cfg_valid = 1'b0; i_cfg_index = sgm_pkg::CfgWidth; i_cfg_data = '0;
        foreach (line_prev[i]) begin
            line_prev[i] = '0;
            line_prev2[i] = '0;
        end
        foreach (win[i, j]) win[i][j] = 0;
        row_q = 0; col_q = 0;
        width_reg = 1024; height_reg = 1024; replicate_reg = 1'b1;

        // flat image gives zero gradient everywhere
        dir_q.push_back('{ROW_CFG, sgm_pkg::CfgWidth, 16'd4, 0, '0});
        dir_q.push_back('{ROW_CFG, sgm_pkg::CfgHeight, 16'd2, 0, '0});
        dir_q.push_back('{ROW_CFG, sgm_pkg::CfgEdge, 16'd1, 0, '0});
        for (int i = 0; i < 8; i++)
            dir_q.push_back('{ROW_PIX, sgm_pkg::CfgWidth, 16'hFFFF, 1, 16'd0});
        // checkerboard with zero padding
        dir_q.push_back('{ROW_CFG, sgm_pkg::CfgEdge, 16'd0, 0, '0});
        for (int i = 0; i < 8; i++)
            dir_q.push_back('{ROW_PIX, sgm_pkg::CfgWidth,
                              ((i + i / 4) % 2) ? 16'hFFFF : 16'h0000, 0, '0});
        // narrowest image, full vertical step
        dir_q.push_back('{ROW_CFG, sgm_pkg::CfgWidth, 16'd2, 0, '0});
        for (int i = 0; i < 4; i++)
            dir_q.push_back('{ROW_PIX, sgm_pkg::CfgWidth,
                              (i < 2) ? 16'h0000 : 16'hFFFF, 0, '0});

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_q[i]) begin
            if (dir_q[i].kind == ROW_CFG) write_reg(dir_q[i].idx, dir_q[i].val);
            else send_pixel(dir_q[i].val, dir_q[i].known, dir_q[i].mag);
        end

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 66; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 66; end
                default: begin idle_pct = 15; stall_pct = 15; end
            endcase
            random_setup();
            send_frames(12);
            if (ph == 0) begin
                // out-of-range sizes clamp
                flush_frame();
                write_reg(sgm_pkg::CfgWidth, 16'd0);
                write_reg(sgm_pkg::CfgHeight, 16'd1);
                send_frames(4);
                write_reg(sgm_pkg::CfgWidth, 16'd1);
                write_reg(sgm_pkg::CfgHeight, 16'd0);
                send_frames(4);
            end else if (ph == 1) begin
                // tallest frame, cut short by a height change mid-frame
                flush_frame();
                write_reg(CfgUnused, 16'hFFFF);
                write_reg(sgm_pkg::CfgWidth, 16'd3);
                write_reg(sgm_pkg::CfgHeight, 16'hFFFF);
                for (int i = 0; i < 9; i++) send_pixel(rand_pixel(), 0, '0);
                write_reg(sgm_pkg::CfgHeight, 16'd2);
                flush_frame();
            end
        end

        stall_pct = 0;
        wait_idle();
        $display("covered %0d pixels and %0d results over %0d register writes,",
                 pixels_sent, results_seen, cfg_writes);
        $display("under four idle and stall mixes with widths from 2 to 8 and clamped sizes");
        if (errors == 0 && mag_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
